// File: hw/rtl/rgbpwm_pkg.sv
// Package: widths, register indexes, reset values and helpers for the RGB PWM color cycler.
package rgbpwm_pkg;

    localparam int LevelW   = 2;
    localparam int EntryW   = 3 * LevelW;
    localparam int Entries  = 8;
    localparam int PaletteW = EntryW * Entries;
    localparam int ModeW    = 4;
    localparam int TickW    = 8;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = PaletteW;

    typedef logic [LevelW-1:0]   level_t;
    typedef logic [EntryW-1:0]   entry_t;
    typedef logic [PaletteW-1:0] palette_t;
    typedef logic [ModeW-1:0]    mode_t;
    typedef logic [TickW-1:0]    tick_t;
    typedef logic [CfgIdxW-1:0]  cfg_idx_t;
    typedef logic [CfgDataW-1:0] cfg_data_t;

    // Register indexes on the configuration channel
    localparam cfg_idx_t CfgDebounce = 2'd0;
    localparam cfg_idx_t CfgAutoStep = 2'd1;
    localparam cfg_idx_t CfgPalette  = 2'd2;

    localparam tick_t    DebounceReset = 8'd10;
    localparam tick_t    AutoStepReset = 8'd125;
    localparam palette_t PaletteReset  = 48'd4384355451651;

    localparam mode_t ModeAuto = 4'd8;
    localparam level_t LevelMax = 2'd3;

    function automatic entry_t palette_entry(palette_t pal, logic [2:0] idx);
        palette_entry = pal[EntryW*int'(idx) +: EntryW];
    endfunction

endpackage

// File: hw/rtl/rgbpwm_in_if.sv
// Interface: tick input channel carrying the raw button level.
interface rgbpwm_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

// File: hw/rtl/rgbpwm_out_if.sv
// Interface: result channel carrying lamp states and color mode.
interface rgbpwm_out_if
    import rgbpwm_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  red_on;
    logic  green_on;
    logic  blue_on;
    mode_t color_mode;

    modport source (output valid, output red_on, output green_on, output blue_on,
                    output color_mode, input ready);
    modport sink (input valid, input red_on, input green_on, input blue_on,
                  input color_mode, output ready);
endinterface

// File: hw/rtl/rgbpwm_cfg_if.sv
// Interface: configuration write channel (register index and data).
interface rgbpwm_cfg_if
    import rgbpwm_pkg::*;
;
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/rgb_led_pwm_color_cycler_unit.sv
// Top level: RGB LED four-phase PWM driver with debounced palette stepping and auto cycling.
//
//  channel  dir  fields
//  in_ch    in   button_level (active low)
//  out_ch   out  red_on, green_on, blue_on, color_mode
//  cfg_ch   in   index (0 debounce, 1 auto step, 2 palette), data
//
// One item per clock while out_ch is not stalling: the tick's whole update is done in the
// accepting cycle and the result lands in the output register, visible the next cycle.
// A new item is accepted whenever the output register is empty or being taken,
// so a held result stalls the input only while out_ch.ready is low.
// Reset (rst_n low, asynchronous) loads palette entry 0, mode 0, all lamps on.
// Configuration writes are always ready and take effect on the next item.
module rgb_led_pwm_color_cycler_unit
    import rgbpwm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rgbpwm_in_if.sink    in_ch,
    rgbpwm_out_if.source out_ch,
    rgbpwm_cfg_if.sink   cfg_ch
);

    localparam entry_t Entry0Reset = PaletteReset[EntryW-1:0];

    tick_t    debounce_reg;
    tick_t    auto_step_reg;
    palette_t palette_reg;

    level_t     phase_reg, phase_next;
    level_t     red_reg, red_next;
    level_t     green_reg, green_next;
    level_t     blue_reg, blue_next;
    mode_t      mode_reg, mode_next;
    tick_t      press_cnt_reg, press_cnt_next;
    logic       latched_reg, latched_next;
    tick_t      auto_cnt_reg, auto_cnt_next;
    logic [2:0] lamp_reg, lamp_next;

    logic       out_valid_reg;
    logic [2:0] out_lamp_reg;
    mode_t      out_mode_reg;

    logic in_accept;
    logic press_event;
    tick_t press_inc;
    tick_t auto_inc;
    entry_t load_entry;
    logic [EntryW-1:0] levels_inc;

    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign in_accept    = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.red_on     = out_lamp_reg[0];
    assign out_ch.green_on   = out_lamp_reg[1];
    assign out_ch.blue_on    = out_lamp_reg[2];
    assign out_ch.color_mode = out_mode_reg;

    assign press_inc  = press_cnt_reg + 1'b1;
    assign auto_inc   = auto_cnt_reg + 1'b1;
    assign load_entry = palette_entry(palette_reg, mode_next[2:0]);

    always_comb
    begin
        // PWM: lamps go dark at their level, relight on phase wrap
        lamp_next = lamp_reg;
        if (phase_reg == red_reg && red_reg != LevelMax)
        begin
            lamp_next[0] = 1'b0;
        end
        if (phase_reg == green_reg && green_reg != LevelMax)
        begin
            lamp_next[1] = 1'b0;
        end
        if (phase_reg == blue_reg && blue_reg != LevelMax)
        begin
            lamp_next[2] = 1'b0;
        end
        phase_next = phase_reg + 1'b1;
        if (phase_next == '0)
        begin
            lamp_next = lamp_next | {blue_reg != '0, green_reg != '0, red_reg != '0};
        end

        // Debounce: count accumulates across releases
        press_cnt_next = press_cnt_reg;
        latched_next   = latched_reg;
        press_event    = 1'b0;
        if (in_ch.button_level)
        begin
            latched_next = 1'b0;
        end
        else if (!latched_reg)
        begin
            if (press_inc == debounce_reg)
            begin
                press_cnt_next = '0;
                latched_next   = 1'b1;
                press_event    = 1'b1;
            end
            else
            begin
                press_cnt_next = press_inc;
            end
        end

        mode_next  = mode_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        if (press_event)
        begin
            mode_next = (mode_reg >= ModeAuto) ? '0 : mode_reg + 1'b1;
            if (mode_next != ModeAuto)
            begin
                red_next   = load_entry[LevelW-1:0];
                green_next = load_entry[2*LevelW-1:LevelW];
                blue_next  = load_entry[3*LevelW-1:2*LevelW];
            end
        end

        // Auto mode: levels form a 6-bit counter, red lowest
        auto_cnt_next = auto_cnt_reg;
        levels_inc    = {blue_next, green_next, red_next} + 1'b1;
        if (mode_next == ModeAuto)
        begin
            if (auto_inc == auto_step_reg)
            begin
                auto_cnt_next = '0;
                red_next      = levels_inc[LevelW-1:0];
                green_next    = levels_inc[2*LevelW-1:LevelW];
                blue_next     = levels_inc[3*LevelW-1:2*LevelW];
            end
            else
            begin
                auto_cnt_next = auto_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DebounceReset;
            auto_step_reg <= AutoStepReset;
            palette_reg   <= PaletteReset;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CfgDebounce: debounce_reg  <= cfg_ch.data[TickW-1:0];
                CfgAutoStep: auto_step_reg <= cfg_ch.data[TickW-1:0];
                CfgPalette:  palette_reg   <= cfg_ch.data[PaletteW-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            red_reg       <= Entry0Reset[LevelW-1:0];
            green_reg     <= Entry0Reset[2*LevelW-1:LevelW];
            blue_reg      <= Entry0Reset[3*LevelW-1:2*LevelW];
            mode_reg      <= '0;
            press_cnt_reg <= '0;
            latched_reg   <= 1'b0;
            auto_cnt_reg  <= '0;
            lamp_reg      <= 3'b111;
        end
        else if (in_accept)
        begin
            phase_reg     <= phase_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            mode_reg      <= mode_next;
            press_cnt_reg <= press_cnt_next;
            latched_reg   <= latched_next;
            auto_cnt_reg  <= auto_cnt_next;
            lamp_reg      <= lamp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_lamp_reg <= lamp_next;
            out_mode_reg <= mode_next;
        end
    end

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= ModeAuto)
        else $error("mode beyond auto cycling");

    a_latched_count: assert property (@(posedge clk) disable iff (!rst_n)
        latched_reg |-> press_cnt_reg == '0)
        else $error("press count nonzero while latched");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg && out_mode_reg == mode_reg)
        else $error("accepted item lost or mode mismatch");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |-> !in_ch.ready)
        else $error("input accepted while result held");

endmodule

// File: test/tb_rgb_led_pwm_color_cycler_unit.sv
// Testbench: button ticks and register writes into the RGB PWM color cycler, each result checked.
module tb_rgb_led_pwm_color_cycler_unit
    import rgbpwm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int       CycleLimit = 200000;
    localparam cfg_idx_t CfgUnused  = 2'd3;

    typedef struct packed {
        logic  red;
        logic  green;
        logic  blue;
        mode_t mode;
    } lamp_result_t;

    logic clk = 1'b0;
    logic rst_n;

    rgbpwm_in_if  in_ch();
    rgbpwm_out_if out_ch();
    rgbpwm_cfg_if cfg_ch();

    rgb_led_pwm_color_cycler_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #5ns clk = ~clk;

    // Predicted block state and register copies
    logic [1:0] pwm_ph;
    level_t     lvl [3];        // 0 red, 1 green, 2 blue
    mode_t      mode_q;
    tick_t      press_cnt;
    logic       press_held;
    tick_t      auto_cnt;
    logic [2:0] lamps;
    tick_t      dbn_ticks;
    tick_t      step_ticks;
    palette_t   pal;

    lamp_result_t pending_lamps [$];

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_req      = 0;
    int mismatch_count = 0;
    int cycle_count   = 0;

    function automatic void load_levels(input logic [2:0] idx);
        logic [EntryW-1:0] e;
        e = EntryW'(pal >> (EntryW * int'(idx)));
        lvl[0] = e[1:0];
        lvl[1] = e[3:2];
        lvl[2] = e[5:4];
    endfunction

    function automatic void reset_prediction();
        dbn_ticks  = DebounceReset;
        step_ticks = AutoStepReset;
        pal        = PaletteReset;
        pwm_ph     = '0;
        load_levels(3'd0);
        mode_q     = '0;
        press_cnt  = '0;
        press_held = 1'b0;
        auto_cnt   = '0;
        lamps      = 3'b111;
    endfunction

    function automatic void advance_pwm_tick(input logic level);
        lamp_result_t r;
        logic         accepted;
        // PWM runs on the levels in force before any color change this tick
        for (int c = 0; c < 3; c++)
            if (pwm_ph == lvl[c] && lvl[c] != LevelMax)
                lamps[c] = 1'b0;
        pwm_ph = pwm_ph + 2'd1;
        if (pwm_ph == 2'd0)
            for (int c = 0; c < 3; c++)
                if (lvl[c] != '0)
                    lamps[c] = 1'b1;

        accepted = 1'b0;
        if (level)
            press_held = 1'b0;
        else if (!press_held)
        begin
            press_cnt = press_cnt + 8'd1;
            if (press_cnt == dbn_ticks)
            begin
                press_cnt  = '0;
                press_held = 1'b1;
                accepted   = 1'b1;
            end
        end
        if (accepted)
        begin
            mode_q = (mode_q >= ModeAuto) ? mode_t'(0) : mode_q + 4'd1;
            if (mode_q < ModeAuto)
                load_levels(mode_q[2:0]);
        end
        if (mode_q == ModeAuto)
        begin
            auto_cnt = auto_cnt + 8'd1;
            if (auto_cnt == step_ticks)
            begin
                auto_cnt = '0;
                lvl[0] = lvl[0] + 2'd1;
                if (lvl[0] == '0)
                begin
                    lvl[1] = lvl[1] + 2'd1;
                    if (lvl[1] == '0)
                        lvl[2] = lvl[2] + 2'd1;
                end
            end
        end

        r.red   = lamps[0];
        r.green = lamps[1];
        r.blue  = lamps[2];
        r.mode  = mode_q;
        pending_lamps.push_back(r);
    endfunction

    function automatic void flag_mismatch(input string what, input lamp_result_t want,
                                          input lamp_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s: expected r%0b g%0b b%0b mode %0d, got r%0b g%0b b%0b mode %0d",
                     $realtime, what, want.red, want.green, want.blue, want.mode,
                     got.red, got.green, got.blue, got.mode);
    endfunction

    // Checker and predictor, all on pre-edge values
    always @(posedge clk)
    begin
        lamp_result_t got;
        lamp_result_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.red   = out_ch.red_on;
                got.green = out_ch.green_on;
                got.blue  = out_ch.blue_on;
                got.mode  = out_ch.color_mode;
                if (pending_lamps.size() == 0)
                begin
                    want = '0;
                    flag_mismatch("unexpected result", want, got);
                end
                else
                begin
                    want = pending_lamps.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.mode !== want.mode)
                        flag_mismatch("result mismatch", want, got);
                end
            end
            if (in_ch.valid && in_ch.ready)
                advance_pwm_tick(in_ch.button_level);
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CfgDebounce: dbn_ticks  = cfg_ch.data[TickW-1:0];
                    CfgAutoStep: step_ticks = cfg_ch.data[TickW-1:0];
                    CfgPalette:  pal        = cfg_ch.data[PaletteW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Result side: random stalls, plus an optional long hold-off
    initial
    begin
        int hold_len;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_len = hold_req;
                hold_req = 0;
                out_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_tick(input logic level);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.button_level <= level;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic wait_results_done();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_lamps.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
        wait_results_done();
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic cfg_data_t rand_palette();
        return cfg_data_t'({$urandom, $urandom});
    endfunction

    // Low byte carries the value, upper bits are junk the block must drop
    function automatic cfg_data_t with_junk(input tick_t v);
        cfg_data_t d;
        d = rand_palette();
        d[TickW-1:0] = v;
        return d;
    endfunction

    function automatic void set_idle(input int in_pct, input int out_pct);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
    endfunction

    task automatic configure_phase(input tick_t dbn, input tick_t step, input palette_t p);
        // clear a partial press count so a smaller threshold is not overshot
        if (dbn_ticks != '0 && dbn_ticks <= 8'd16)
        begin
            repeat (int'(dbn_ticks)) send_tick(1'b0);
            send_tick(1'b1);
        end
        write_reg(CfgDebounce, with_junk(dbn));
        write_reg(CfgAutoStep, with_junk(step));
        write_reg(CfgPalette, p);
    endtask

    // Mostly clean presses long enough to be accepted, some noise in between
    task automatic random_press_traffic(input int n);
        int sent;
        int run;
        int kind;
        int need;
        sent = 0;
        need = (dbn_ticks == '0) ? 256 : int'(dbn_ticks);
        while (sent < n)
        begin
            kind = (sent == 0) ? 0 : int'($urandom_range(9));
            if (kind < 7)
            begin
                run = need + int'($urandom_range(2));
                repeat (run)
                    if (sent < n)
                    begin
                        send_tick(1'b0);
                        sent++;
                    end
                run = 1 + int'($urandom_range(3));
                repeat (run)
                    if (sent < n)
                    begin
                        send_tick(1'b1);
                        sent++;
                    end
            end
            else
            begin
                run = 1 + int'($urandom_range(3));
                repeat (run)
                    if (sent < n)
                    begin
                        send_tick(1'($urandom_range(1)));
                        sent++;
                    end
            end
        end
    endtask

    task automatic walk_to_auto_mode();
        int need;
        need = (dbn_ticks == '0) ? 256 : int'(dbn_ticks);
        wait_results_done();
        while (mode_q != ModeAuto)
        begin
            repeat (need) send_tick(1'b0);
            send_tick(1'b1);
            wait_results_done();
        end
    endtask

    task automatic test_reset_state();
        set_idle(0, 0);
        send_tick(1'b1);
        repeat (int'(DebounceReset)) send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic test_mode_walk_and_wrap();
        write_reg(CfgDebounce, with_junk(8'd1));
        write_reg(CfgAutoStep, cfg_data_t'(1));
        write_reg(CfgPalette, '1);
        // entry 2 up to automatic cycling; levels keep entry 7 and step at once
        repeat (7)
        begin
            send_tick(1'b0);
            send_tick(1'b1);
        end
        // next press leaves auto cycling for entry 0
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic test_random_no_idle();
        configure_phase(tick_t'($urandom_range(2, 4)), tick_t'($urandom_range(1, 5)),
                        rand_palette());
        write_reg(CfgUnused, rand_palette());
        set_idle(0, 0);
        random_press_traffic(80);
    endtask

    task automatic test_random_sender_gaps();
        configure_phase(8'd1, 8'd1, '0);
        set_idle(53, 0);
        random_press_traffic(40);
        wait_results_done();
        random_press_traffic(40);
    endtask

    task automatic test_random_receiver_stalls();
        configure_phase(8'd3, tick_t'($urandom_range(1, 6)), rand_palette());
        set_idle(0, 53);
        hold_req = 300;
        random_press_traffic(100);
    endtask

    task automatic test_auto_step_wrap();
        configure_phase(8'd1, 8'd0, rand_palette());
        set_idle(6, 6);
        walk_to_auto_mode();
        // zero step setting: the 8-bit counter wraps, one step per 256 ticks
        repeat (260) send_tick(1'b1);
    endtask

    task automatic test_debounce_max();
        configure_phase(8'd255, 8'd255, rand_palette());
        set_idle(0, 53);
        random_press_traffic(260);
    endtask

    task automatic test_debounce_zero();
        configure_phase(8'd0, 8'd1, rand_palette());
        set_idle(53, 0);
        random_press_traffic(260);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.button_level = 1'b1;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CfgDebounce;
        cfg_ch.data        = '0;
        reset_prediction();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_mode_walk_and_wrap();
        test_random_no_idle();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_auto_step_wrap();
        test_debounce_max();
        test_debounce_zero();

        wait_results_done();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_lamps.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
